// ===== design/scatter_rgbwt_accumulator_macros.svh =====
// Assertion macros for the scatter RGBWT accumulator; they sample on clk and are off in reset.
`ifndef SCATTER_RGBWT_ACCUMULATOR_MACROS_SVH
`define SCATTER_RGBWT_ACCUMULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRGBWT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRGBWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/srgbwt_pkg.sv =====
// Shared types and constants for the scatter RGBWT accumulator.
package srgbwt_pkg;

    localparam int COORD_W         = 32;
    localparam int GRID_W          = 9;
    localparam int COLOR_BITS      = 16;
    localparam int SUM_BITS        = 40;
    localparam int TRANS_W         = COLOR_BITS + 1;
    localparam int GRID_PIXELS_DEF = 65536;
    localparam int APB_DATA_W      = 32;
    localparam int REG_ADDR_W      = 5;
    localparam int REG_IDX_W       = 3;

    // Transmittance of 1.0.
    localparam logic [TRANS_W-1:0] UNITY = {1'b1, {COLOR_BITS{1'b0}}};

    // Register indexes, at byte address four times the index.
    localparam logic [REG_IDX_W-1:0] REG_X_ORIGIN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_SCALE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_ORIGIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_SCALE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd5;

    // Register reset values.
    localparam logic [COORD_W-1:0] ORIGIN_RST = 32'h0000_0000;
    localparam logic [COORD_W-1:0] SCALE_RST  = 32'h0001_0000;
    localparam logic [GRID_W-1:0]  GRID_RST   = 9'd256;

    typedef struct packed {
        logic [COORD_W-1:0] x_origin;
        logic [COORD_W-1:0] x_scale;
        logic [COORD_W-1:0] y_origin;
        logic [COORD_W-1:0] y_scale;
        logic [GRID_W-1:0]  grid_width;
        logic [GRID_W-1:0]  grid_height;
    } cfg_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] red_sum;
        logic [SUM_BITS-1:0] green_sum;
        logic [SUM_BITS-1:0] blue_sum;
        logic [SUM_BITS-1:0] weight_sum;
        logic [TRANS_W-1:0]  trans;
    } pixel_entry_t;

    localparam int ENTRY_W = $bits(pixel_entry_t);

    localparam pixel_entry_t ENTRY_RST = '{
        red_sum:    '0,
        green_sum:  '0,
        blue_sum:   '0,
        weight_sum: '0,
        trans:      UNITY
    };

endpackage

// ===== design/scatter_rgbwt_accumulator.sv =====
// Top level of the scatter RGBWT accumulator: sequencer, shared multiplier and pixel store.
// After reset the block sweeps the pixel store once, one entry a cycle, to clear the sums and
// set every transmittance to 1.0; during the sweep in_ready stays low while configuration
// writes are still taken. The block then works on one item at a time. A plot beat is worked
// on by one 33 by 32 bit multiplier, shared by the two bin computations, the three colour
// products and the transmittance product, around one read and one write of the pixel store.
// A dropped point goes from its address check straight to the result; a pixel read checks
// its index, reads the store and loads the entry, and a read of an index outside the grid
// goes from its check straight to the result. in_ready rises together with out_valid, so the
// next beat can be accepted in the cycle in which each result appears. A finished result
// waits in an output register while the next input beat is taken and worked on; a second
// result that finds the register still full holds the sequencer until it is taken.
module scatter_rgbwt_accumulator #(
    parameter int GRID_PIXELS = srgbwt_pkg::GRID_PIXELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srgbwt_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [srgbwt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [srgbwt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                pready,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [srgbwt_pkg::COORD_W-1:0] x_coord,
    input  logic signed [srgbwt_pkg::COORD_W-1:0] y_coord,
    input  logic [srgbwt_pkg::COLOR_BITS-1:0]   red,
    input  logic [srgbwt_pkg::COLOR_BITS-1:0]   green,
    input  logic [srgbwt_pkg::COLOR_BITS-1:0]   blue,
    input  logic [srgbwt_pkg::COLOR_BITS-1:0]   alpha,
    input  logic [15:0]                         pixel_index,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                in_range,
    output logic [srgbwt_pkg::SUM_BITS-1:0]     red_total,
    output logic [srgbwt_pkg::SUM_BITS-1:0]     green_total,
    output logic [srgbwt_pkg::SUM_BITS-1:0]     blue_total,
    output logic [srgbwt_pkg::SUM_BITS-1:0]     weight_total,
    output logic [srgbwt_pkg::TRANS_W-1:0]      transmittance
);
    import srgbwt_pkg::*;

    localparam int                ADDR_W     = $clog2(GRID_PIXELS);
    localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(GRID_PIXELS - 1);
    localparam logic [31:0]       GRID_LIMIT = 32'(GRID_PIXELS);
    localparam int                WHOLE_W    = COORD_W + 1;
    localparam int                CALC_W     = 2 * GRID_W;

    // Sequencer states.
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_MULX  = 4'd2;
    localparam logic [3:0] ST_MULY  = 4'd3;
    localparam logic [3:0] ST_ADDR  = 4'd4;
    localparam logic [3:0] ST_RCHK  = 4'd5;
    localparam logic [3:0] ST_READ  = 4'd6;
    localparam logic [3:0] ST_RLOAD = 4'd7;
    localparam logic [3:0] ST_MULR  = 4'd8;
    localparam logic [3:0] ST_MULG  = 4'd9;
    localparam logic [3:0] ST_MULB  = 4'd10;
    localparam logic [3:0] ST_MULT  = 4'd11;
    localparam logic [3:0] ST_WRITE = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    cfg_t                    cfg;

    // Control state
    logic [3:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // Item held while it is worked on
    logic                    action_reg;
    logic [WHOLE_W-1:0]      mag_x_reg, mag_y_reg;
    logic                    neg_x_reg, neg_y_reg;
    logic [COLOR_BITS-1:0]   red_reg, green_reg, blue_reg, alpha_reg;
    logic [15:0]             pixel_index_reg;
    logic [WHOLE_W-1:0]      whole_x_reg, whole_y_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic                    ok_reg;
    logic [COLOR_BITS-1:0]   inc_r_reg, inc_g_reg, inc_b_reg;
    logic [TRANS_W-1:0]      trans_reg;
    pixel_entry_t            res_reg;

    // Output register
    logic                    in_range_reg;
    logic [SUM_BITS-1:0]     red_total_reg, green_total_reg, blue_total_reg, weight_total_reg;
    logic [TRANS_W-1:0]      trans_out_reg;

    // Datapath signals
    logic                    accept;
    logic                    out_load;
    logic [WHOLE_W-1:0]      dx, dy, mag_dx, mag_dy;
    logic [COORD_W-1:0]      xscale_mag, yscale_mag;
    logic [WHOLE_W-1:0]      mul_a;
    logic [COORD_W-1:0]      mul_b;
    logic [2*COORD_W:0]      mul_prod;
    logic [CALC_W-1:0]       addr_calc, cells;
    logic [31:0]             addr_wide, idx_wide;
    logic                    plot_ok, read_ok;
    pixel_entry_t            rd_entry, new_entry;
    logic [ENTRY_W-1:0]      rd_data;
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr;
    pixel_entry_t            mem_wdata;

    // Bin of a scaled offset is usable when not negative and below the limit.
    function automatic logic bin_ok(input logic [WHOLE_W-1:0] whole, input logic neg,
                                    input logic [GRID_W-1:0] limit);
        return !(neg && (whole != '0)) && (whole < WHOLE_W'(limit));
    endfunction

    // Sum plus an increment, sticking at all ones.
    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] sum,
                                                    input logic [COLOR_BITS-1:0] inc);
        logic [SUM_BITS:0] total;
        total = {1'b0, sum} + (SUM_BITS + 1)'(inc);
        return total[SUM_BITS] ? {SUM_BITS{1'b1}} : total[SUM_BITS-1:0];
    endfunction

    srgbwt_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    srgbwt_pixel_ram #(
        .DEPTH (GRID_PIXELS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    assign pready   = 1'b1;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign rd_entry = rd_data;

    // Offsets from the origins, as magnitudes, with the sign of the product kept apart.
    assign dx         = {x_coord[COORD_W-1], x_coord} - {cfg.x_origin[COORD_W-1], cfg.x_origin};
    assign dy         = {y_coord[COORD_W-1], y_coord} - {cfg.y_origin[COORD_W-1], cfg.y_origin};
    assign mag_dx     = dx[WHOLE_W-1] ? (WHOLE_W'(0) - dx) : dx;
    assign mag_dy     = dy[WHOLE_W-1] ? (WHOLE_W'(0) - dy) : dy;
    assign xscale_mag = cfg.x_scale[COORD_W-1] ? (COORD_W'(0) - cfg.x_scale) : cfg.x_scale;
    assign yscale_mag = cfg.y_scale[COORD_W-1] ? (COORD_W'(0) - cfg.y_scale) : cfg.y_scale;

    // Shared multiplier operands, chosen by the sequencer.
    always_comb
    begin
        case (state_reg)
            ST_MULX:
            begin
                mul_a = mag_x_reg;
                mul_b = xscale_mag;
            end
            ST_MULY:
            begin
                mul_a = mag_y_reg;
                mul_b = yscale_mag;
            end
            ST_MULR:
            begin
                mul_a = WHOLE_W'(red_reg);
                mul_b = COORD_W'(alpha_reg);
            end
            ST_MULG:
            begin
                mul_a = WHOLE_W'(green_reg);
                mul_b = COORD_W'(alpha_reg);
            end
            ST_MULB:
            begin
                mul_a = WHOLE_W'(blue_reg);
                mul_b = COORD_W'(alpha_reg);
            end
            ST_MULT:
            begin
                mul_a = WHOLE_W'(rd_entry.trans);
                mul_b = COORD_W'(UNITY - TRANS_W'(alpha_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = {{COORD_W{1'b0}}, mul_a} * {{WHOLE_W{1'b0}}, mul_b};

    // Column-major pixel address and the checks on it.
    assign addr_calc = {{GRID_W{1'b0}}, whole_x_reg[GRID_W-1:0]}
                       * {{GRID_W{1'b0}}, cfg.grid_height}
                       + {{GRID_W{1'b0}}, whole_y_reg[GRID_W-1:0]};
    assign addr_wide = 32'(addr_calc);
    assign plot_ok   = bin_ok(whole_x_reg, neg_x_reg, cfg.grid_width)
                       && bin_ok(whole_y_reg, neg_y_reg, cfg.grid_height)
                       && (addr_wide < GRID_LIMIT);

    // Read index check against the grid in use and the store depth.
    assign cells    = {{GRID_W{1'b0}}, cfg.grid_width} * {{GRID_W{1'b0}}, cfg.grid_height};
    assign idx_wide = 32'(pixel_index_reg);
    assign read_ok  = (CALC_W'(pixel_index_reg) < cells) && (idx_wide < GRID_LIMIT);

    // Updated pixel from the read entry and the registered products.
    always_comb
    begin
        new_entry.red_sum    = sat_add(rd_entry.red_sum, inc_r_reg);
        new_entry.green_sum  = sat_add(rd_entry.green_sum, inc_g_reg);
        new_entry.blue_sum   = sat_add(rd_entry.blue_sum, inc_b_reg);
        new_entry.weight_sum = sat_add(rd_entry.weight_sum, alpha_reg);
        new_entry.trans      = trans_reg;
    end

    // Store access: the clearing sweep, the read of a pixel and its write-back.
    assign mem_re    = (state_reg == ST_READ);
    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? ENTRY_RST : new_entry;

    // Sequencer next state.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == CLEAR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = action ? ST_RCHK : ST_MULX;
                end
            end
            ST_MULX:  state_next = ST_MULY;
            ST_MULY:  state_next = ST_ADDR;
            ST_ADDR:  state_next = plot_ok ? ST_READ : ST_DONE;
            ST_RCHK:  state_next = read_ok ? ST_READ : ST_DONE;
            ST_READ:  state_next = action_reg ? ST_RLOAD : ST_MULR;
            ST_RLOAD: state_next = ST_DONE;
            ST_MULR:  state_next = ST_MULG;
            ST_MULG:  state_next = ST_MULB;
            ST_MULB:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Output beat valid: set on load, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, loaded step by step.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_reg      <= action;
                    mag_x_reg       <= mag_dx;
                    mag_y_reg       <= mag_dy;
                    neg_x_reg       <= dx[WHOLE_W-1] ^ cfg.x_scale[COORD_W-1];
                    neg_y_reg       <= dy[WHOLE_W-1] ^ cfg.y_scale[COORD_W-1];
                    red_reg         <= red;
                    green_reg       <= green;
                    blue_reg        <= blue;
                    alpha_reg       <= alpha;
                    pixel_index_reg <= pixel_index;
                end
            end
            ST_MULX:  whole_x_reg <= mul_prod[2*COORD_W:COORD_W];
            ST_MULY:  whole_y_reg <= mul_prod[2*COORD_W:COORD_W];
            ST_ADDR:
            begin
                addr_reg <= addr_wide[ADDR_W-1:0];
                ok_reg   <= plot_ok;
            end
            ST_RCHK:
            begin
                addr_reg <= idx_wide[ADDR_W-1:0];
                ok_reg   <= read_ok;
            end
            ST_RLOAD: res_reg   <= rd_entry;
            ST_MULR:  inc_r_reg <= mul_prod[2*COLOR_BITS-1:COLOR_BITS];
            ST_MULG:  inc_g_reg <= mul_prod[2*COLOR_BITS-1:COLOR_BITS];
            ST_MULB:  inc_b_reg <= mul_prod[2*COLOR_BITS-1:COLOR_BITS];
            ST_MULT:  trans_reg <= mul_prod[COLOR_BITS+TRANS_W-1:COLOR_BITS];
            ST_WRITE: res_reg   <= new_entry;
            default:  ;
        endcase
    end

    // Output register; a dropped point or a bad index gives zeros.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            in_range_reg     <= ok_reg;
            red_total_reg    <= ok_reg ? res_reg.red_sum    : '0;
            green_total_reg  <= ok_reg ? res_reg.green_sum  : '0;
            blue_total_reg   <= ok_reg ? res_reg.blue_sum   : '0;
            weight_total_reg <= ok_reg ? res_reg.weight_sum : '0;
            trans_out_reg    <= ok_reg ? res_reg.trans      : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign in_range      = in_range_reg;
    assign red_total     = red_total_reg;
    assign green_total   = green_total_reg;
    assign blue_total    = blue_total_reg;
    assign weight_total  = weight_total_reg;
    assign transmittance = trans_out_reg;

    // Checks on the sequencer and the result.
`include "scatter_rgbwt_accumulator_macros.svh"

    `SRGBWT_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE, "beat accepted but sequencer stayed idle")
    `SRGBWT_ASSERT_SAME(a_write_only_when_ok, state_reg == ST_WRITE, ok_reg, "pixel written back for a dropped point")
    `SRGBWT_ASSERT_SAME(a_trans_bounded, out_valid, transmittance <= UNITY, "transmittance above 1.0")
    `SRGBWT_ASSERT_SAME(a_dropped_is_zero, out_valid && !in_range, (red_total == '0) && (green_total == '0) && (blue_total == '0) && (weight_total == '0) && (transmittance == '0), "out-of-range result carries nonzero channels")

endmodule

// ===== design/srgbwt_apb_regs.sv =====
// APB configuration registers of the scatter RGBWT accumulator.
module srgbwt_apb_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srgbwt_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [srgbwt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [srgbwt_pkg::APB_DATA_W-1:0]   prdata,
    output srgbwt_pkg::cfg_t                    cfg
);
    import srgbwt_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[REG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin    <= ORIGIN_RST;
            cfg_reg.x_scale     <= SCALE_RST;
            cfg_reg.y_origin    <= ORIGIN_RST;
            cfg_reg.y_scale     <= SCALE_RST;
            cfg_reg.grid_width  <= GRID_RST;
            cfg_reg.grid_height <= GRID_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_X_ORIGIN:    cfg_reg.x_origin    <= pwdata;
                REG_X_SCALE:     cfg_reg.x_scale     <= pwdata;
                REG_Y_ORIGIN:    cfg_reg.y_origin    <= pwdata;
                REG_Y_SCALE:     cfg_reg.y_scale     <= pwdata;
                REG_GRID_WIDTH:  cfg_reg.grid_width  <= pwdata[GRID_W-1:0];
                REG_GRID_HEIGHT: cfg_reg.grid_height <= pwdata[GRID_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read-back multiplexer; unused addresses read as zero.
    always_comb
    begin
        case (reg_idx)
            REG_X_ORIGIN:    prdata = cfg_reg.x_origin;
            REG_X_SCALE:     prdata = cfg_reg.x_scale;
            REG_Y_ORIGIN:    prdata = cfg_reg.y_origin;
            REG_Y_SCALE:     prdata = cfg_reg.y_scale;
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(cfg_reg.grid_width);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(cfg_reg.grid_height);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== design/srgbwt_pixel_ram.sv =====
// Single-port-write, single-port-read pixel memory with a registered read.
module srgbwt_pixel_ram #(
    parameter int DEPTH = srgbwt_pkg::GRID_PIXELS_DEF,
    parameter int WIDTH = srgbwt_pkg::ENTRY_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// ===== sim/scatter_rgbwt_accumulator_tb.sv =====
// Self-checking testbench for the scatter RGBWT accumulator, with its own pixel-store predictor.
module scatter_rgbwt_accumulator_tb;
    import srgbwt_pkg::*;

    localparam logic ACT_PLOT = 1'b0;
    localparam logic ACT_READ = 1'b1;
    localparam int PIXELS = GRID_PIXELS_DEF;
    localparam int STALL_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOT_DEPTH = 48;
    localparam logic [SUM_BITS-1:0] SUM_TOP = '1;

    typedef struct packed {
        logic                  action;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] alpha;
        logic [15:0]           idx;
    } raster_req_t;

    typedef struct packed {
        logic                in_range;
        logic [SUM_BITS-1:0] red;
        logic [SUM_BITS-1:0] green;
        logic [SUM_BITS-1:0] blue;
        logic [SUM_BITS-1:0] weight;
        logic [TRANS_W-1:0]  trans;
    } pixel_view_t;

    // Clock, reset and block ports.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [REG_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic action = 1'b0;
    logic [COORD_W-1:0] x_coord = '0;
    logic [COORD_W-1:0] y_coord = '0;
    logic [COLOR_BITS-1:0] red = '0;
    logic [COLOR_BITS-1:0] green = '0;
    logic [COLOR_BITS-1:0] blue = '0;
    logic [COLOR_BITS-1:0] alpha = '0;
    logic [15:0] pixel_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic in_range;
    logic [SUM_BITS-1:0] red_total;
    logic [SUM_BITS-1:0] green_total;
    logic [SUM_BITS-1:0] blue_total;
    logic [SUM_BITS-1:0] weight_total;
    logic [TRANS_W-1:0] transmittance;

    // Predicted pixel store and plot setting.
    logic [SUM_BITS-1:0] shade_red [PIXELS];
    logic [SUM_BITS-1:0] shade_green [PIXELS];
    logic [SUM_BITS-1:0] shade_blue [PIXELS];
    logic [SUM_BITS-1:0] shade_weight [PIXELS];
    logic [TRANS_W-1:0]  shade_trans [PIXELS];
    cfg_t plot_cfg;

    // Stimulus and checking state.
    raster_req_t raster_backlog[$];
    pixel_view_t due_pixels[$];
    logic [15:0] hot_pixels[$];
    logic in_taken = 1'b0;
    logic idling = 1'b1;
    logic hold_go = 1'b0;
    logic hold_seen = 1'b0;
    int hold_left = 0;
    int give_gap = 0;
    int take_gap = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int plots_landed = 0;
    int plots_dropped = 0;
    int reads_valid = 0;
    int reads_invalid = 0;
    int settings_used = 1;

    scatter_rgbwt_accumulator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .pixel_index   (pixel_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .in_range      (in_range),
        .red_total     (red_total),
        .green_total   (green_total),
        .blue_total    (blue_total),
        .weight_total  (weight_total),
        .transmittance (transmittance)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Bin of (coord - origin) * scale truncated toward zero; false when it is -1 or less,
    // or at or beyond the limit.
    function automatic logic land_bin(input logic [COORD_W-1:0] coord,
                                      input logic [COORD_W-1:0] origin,
                                      input logic [COORD_W-1:0] scale,
                                      input logic [GRID_W-1:0] limit,
                                      output int unsigned bin);
        longint signed span;
        longint unsigned span_mag;
        longint unsigned scale_mag;
        longint unsigned whole;
        logic flip;
        span = longint'($signed(coord)) - longint'($signed(origin));
        flip = (span < 0) != scale[COORD_W-1];
        span_mag = (span < 0) ? -span : span;
        scale_mag = scale[COORD_W-1] ? -longint'($signed(scale)) : longint'($signed(scale));
        whole = (span_mag * scale_mag) >> 32;
        bin = whole[31:0];
        if (flip && whole != 0)
            return 1'b0;
        return whole < limit;
    endfunction

    // Column-major address of a point, false when the point falls off the store.
    function automatic logic land_pixel(input raster_req_t req, output int unsigned addr);
        int unsigned col;
        int unsigned row;
        addr = 0;
        if (!land_bin(req.x, plot_cfg.x_origin, plot_cfg.x_scale, plot_cfg.grid_width, col))
            return 1'b0;
        if (!land_bin(req.y, plot_cfg.y_origin, plot_cfg.y_scale, plot_cfg.grid_height, row))
            return 1'b0;
        addr = col * 32'(plot_cfg.grid_height) + row;
        return addr < PIXELS;
    endfunction

    function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] acc,
                                                    input logic [31:0] inc);
        logic [SUM_BITS:0] total;
        total = {1'b0, acc} + (SUM_BITS + 1)'(inc);
        return total[SUM_BITS] ? SUM_TOP : total[SUM_BITS-1:0];
    endfunction

    function automatic pixel_view_t pixel_at(input int unsigned addr);
        pixel_view_t outcome;
        outcome.in_range = 1'b1;
        outcome.red = shade_red[addr];
        outcome.green = shade_green[addr];
        outcome.blue = shade_blue[addr];
        outcome.weight = shade_weight[addr];
        outcome.trans = shade_trans[addr];
        return outcome;
    endfunction

    // Applies one accepted beat to the predicted store and returns the pixel it reports.
    function automatic pixel_view_t rasterize_beat(input raster_req_t req);
        pixel_view_t outcome;
        int unsigned addr;
        int unsigned cells;
        logic [31:0] tint;
        logic [2*TRANS_W-1:0] fade;
        outcome = '0;
        cells = 32'(plot_cfg.grid_width) * 32'(plot_cfg.grid_height);
        if (req.action == ACT_READ)
        begin
            if (32'(req.idx) < cells)
                outcome = pixel_at(32'(req.idx));
            return outcome;
        end
        if (!land_pixel(req, addr))
            return outcome;
        tint = 32'(req.red) * 32'(req.alpha);
        shade_red[addr] = sat_sum(shade_red[addr], tint >> COLOR_BITS);
        tint = 32'(req.green) * 32'(req.alpha);
        shade_green[addr] = sat_sum(shade_green[addr], tint >> COLOR_BITS);
        tint = 32'(req.blue) * 32'(req.alpha);
        shade_blue[addr] = sat_sum(shade_blue[addr], tint >> COLOR_BITS);
        shade_weight[addr] = sat_sum(shade_weight[addr], 32'(req.alpha));
        fade = (2 * TRANS_W)'(shade_trans[addr])
               * (2 * TRANS_W)'(UNITY - TRANS_W'(req.alpha));
        shade_trans[addr] = fade[COLOR_BITS+TRANS_W-1:COLOR_BITS];
        return pixel_at(addr);
    endfunction

    // A coordinate whose bin lies mostly inside the grid, with a margin on either side.
    function automatic logic [COORD_W-1:0] aim_coord(input logic [COORD_W-1:0] origin,
                                                     input logic [COORD_W-1:0] scale,
                                                     input logic [GRID_W-1:0] limit);
        longint unsigned reach;
        longint unsigned scale_mag;
        longint signed step;
        scale_mag = scale[COORD_W-1] ? -longint'($signed(scale)) : longint'($signed(scale));
        if (scale_mag == 0)
            return $urandom;
        reach = ((longint'(limit) + 2) << 32) / scale_mag;
        if (reach > 64'h7FFF_FFFF)
            reach = 64'h7FFF_FFFF;
        step = longint'($urandom_range(0, 32'(reach + reach / 8))) - longint'(reach / 8);
        if (scale[COORD_W-1])
            step = -step;
        return origin + step[COORD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (mismatches < 10)
            $display("Mismatch on %s at %0t: expected %0h, got %0h", what, $time, want, got);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endtask

    // Input and output beats are observed here at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch_beats
        pixel_view_t want;
        raster_req_t req;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                req = '{action, x_coord, y_coord, red, green, blue, alpha, pixel_index};
                want = rasterize_beat(req);
                due_pixels.push_back(want);
                if (req.action == ACT_READ)
                begin
                    if (want.in_range) reads_valid++;
                    else reads_invalid++;
                end
                else
                begin
                    if (want.in_range) plots_landed++;
                    else plots_dropped++;
                end
            end
            if (out_valid && out_ready)
            begin
                if (due_pixels.size() == 0)
                    report_mismatch("unexpected result beat", '0, 64'd1);
                else
                begin
                    want = due_pixels.pop_front();
                    check_field("in_range", want.in_range, in_range);
                    check_field("red_total", want.red, red_total);
                    check_field("green_total", want.green, green_total);
                    check_field("blue_total", want.blue, blue_total);
                    check_field("weight_total", want.weight, weight_total);
                    check_field("transmittance", want.trans, transmittance);
                end
            end
            quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                            0 : quiet_cycles + 1;
        end
    end

    // Sender: offers queued beats at the falling edge, with random bursts of idle cycles.
    always @(negedge clk)
    begin : feed_points
        raster_req_t req;
        if (in_valid && !in_taken)
        begin
            // The offered beat stays until it is taken.
        end
        else if (give_gap > 0)
        begin
            in_valid <= 1'b0;
            give_gap <= give_gap - 1;
        end
        else if (raster_backlog.size() > 0 && idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            give_gap <= $urandom_range(0, 16);
        end
        else if (raster_backlog.size() > 0)
        begin
            req = raster_backlog.pop_front();
            in_valid <= 1'b1;
            action <= req.action;
            x_coord <= req.x;
            y_coord <= req.y;
            red <= req.red;
            green <= req.green;
            blue <= req.blue;
            alpha <= req.alpha;
            pixel_index <= req.idx;
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver: random stall bursts, plus one long hold-off when requested.
    always @(negedge clk)
    begin : drain_pixels
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (take_gap > 0)
        begin
            take_gap <= take_gap - 1;
            out_ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            take_gap <= $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin : stall_guard
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Register write with a read-back, both over the configuration port.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        logic [31:0] back;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        back = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        want = value;
        case (idx)
            REG_X_ORIGIN:    plot_cfg.x_origin = value;
            REG_X_SCALE:     plot_cfg.x_scale = value;
            REG_Y_ORIGIN:    plot_cfg.y_origin = value;
            REG_Y_SCALE:     plot_cfg.y_scale = value;
            REG_GRID_WIDTH:
            begin
                plot_cfg.grid_width = value[GRID_W-1:0];
                want = {23'd0, value[GRID_W-1:0]};
            end
            REG_GRID_HEIGHT:
            begin
                plot_cfg.grid_height = value[GRID_W-1:0];
                want = {23'd0, value[GRID_W-1:0]};
            end
            default: ;
        endcase
        check_field("register read-back", want, back);
    endtask

    // Waits until every offered beat has been taken and every result has come back.
    task automatic drain_results();
        while (raster_backlog.size() > 0 || in_valid || due_pixels.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [31:0] x_org, input logic [31:0] x_scl,
                                 input logic [31:0] y_org, input logic [31:0] y_scl,
                                 input logic [31:0] width, input logic [31:0] height);
        drain_results();
        write_reg(REG_X_ORIGIN, x_org);
        write_reg(REG_X_SCALE, x_scl);
        write_reg(REG_Y_ORIGIN, y_org);
        write_reg(REG_Y_SCALE, y_scl);
        write_reg(REG_GRID_WIDTH, width);
        write_reg(REG_GRID_HEIGHT, height);
        settings_used++;
        @(posedge clk);
    endtask

    task automatic queue_plot(input logic [31:0] x, input logic [31:0] y,
                              input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic [15:0] a);
        raster_backlog.push_back('{ACT_PLOT, x, y, r, g, b, a, 16'($urandom)});
    endtask

    task automatic queue_read(input logic [15:0] idx);
        raster_backlog.push_back('{ACT_READ, $urandom, $urandom, 16'($urandom),
                                   16'($urandom), 16'($urandom), 16'($urandom), idx});
    endtask

    // Random traffic: mostly points aimed at the grid, some wild points and pixel reads.
    task automatic queue_mixed(input int count);
        raster_req_t req;
        int unsigned addr;
        int unsigned cells;
        int unsigned pick;
        repeat (count)
        begin
            req = '{ACT_PLOT, $urandom, $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom)};
            cells = 32'(plot_cfg.grid_width) * 32'(plot_cfg.grid_height);
            if (cells > PIXELS)
                cells = PIXELS;
            if ($urandom_range(0, 99) < 30)
            begin
                req.action = ACT_READ;
                pick = $urandom_range(0, 9);
                if (pick < 5 && hot_pixels.size() > 0)
                    req.idx = hot_pixels[$urandom_range(0, hot_pixels.size() - 1)];
                else if (pick < 9 && cells > 0)
                    req.idx = 16'($urandom_range(0, cells - 1));
            end
            else
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    req.x = aim_coord(plot_cfg.x_origin, plot_cfg.x_scale, plot_cfg.grid_width);
                    req.y = aim_coord(plot_cfg.y_origin, plot_cfg.y_scale,
                                      plot_cfg.grid_height);
                end
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    req.alpha = '0;
                else if (pick == 1)
                    req.alpha = '1;
                if (land_pixel(req, addr))
                begin
                    hot_pixels.push_back(addr[15:0]);
                    if (hot_pixels.size() > HOT_DEPTH)
                        void'(hot_pixels.pop_front());
                end
            end
            raster_backlog.push_back(req);
        end
    endtask

    initial
    begin : run_phases
        // The predicted store starts as the block's store does after its clearing sweep.
        plot_cfg = '{ORIGIN_RST, SCALE_RST, ORIGIN_RST, SCALE_RST, GRID_RST, GRID_RST};
        for (int i = 0; i < PIXELS; i++)
        begin
            shade_red[i] = '0;
            shade_green[i] = '0;
            shade_blue[i] = '0;
            shade_weight[i] = '0;
            shade_trans[i] = UNITY;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed beats under the reset setting: one unit per bin on a 256 by 256 grid.
        queue_read(16'd0);
        queue_read(16'hFFFF);
        queue_plot(32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_plot(32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_plot(32'h0000_8000, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        // Just below zero still truncates to the first bin; minus one is dropped.
        queue_plot(32'hFFFF_8000, 32'h0, 16'h1234, 16'h5678, 16'h9ABC, 16'h4000);
        queue_plot(32'hFFFF_0000, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_plot(32'h0, 32'hFFFF_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Last column and row, then one past each.
        queue_plot(32'h00FF_FFFF, 32'h00FF_FFFF, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hC000);
        queue_plot(32'h0100_0000, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_plot(32'h0, 32'h0100_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_plot(32'h7FFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_plot(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_plot(32'h0003_3333, 32'h0007_B333, 16'h1234, 16'h8000, 16'hFFFF, 16'h8000);
        queue_plot(32'h0003_3333, 32'h0007_B333, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h0001);
        queue_read(16'd775);
        queue_read(16'd0);
        queue_read(16'hFFFF);
        queue_plot(32'h0001_0000, 32'h0001_0000, 16'h0, 16'hFFFF, 16'h5555, 16'h8000);
        queue_plot(32'h0001_0000, 32'h0001_0000, 16'hFFFF, 16'h0, 16'hAAAA, 16'hFFFF);
        queue_read(16'd257);
        queue_mixed(150);

        // Small grid with a downward y axis; the receiver holds off while points keep coming.
        apply_setting(32'hFFF6_0000, 32'h0001_8000, 32'h0008_0000, 32'hFFFE_C000, 16, 12);
        hold_go = ~hold_go;
        queue_mixed(130);

        // Extreme origins and scales on a single-row grid.
        apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 256, 1);
        queue_mixed(100);

        // Zero-width grid: every point and every read is out of range.
        apply_setting(32'h0, 32'h0000_0001, 32'h0001_0000, 32'hFFFF_FFFF, 0, 256);
        queue_mixed(30);

        // Grid larger than the store: far columns fall off the end.
        apply_setting(32'h0, 32'h0001_0000, 32'h0, 32'h0000_8000, 300, 300);
        queue_mixed(100);

        // Fine x bins and coarse y bins; the last stretch runs with no idling.
        apply_setting(32'hFFFD_8000, 32'h0040_0000, 32'h0020_0000, 32'hFFFF_C000, 256, 256);
        queue_mixed(90);
        drain_results();
        idling = 1'b0;
        queue_mixed(70);
        drain_results();

        $display("Run covered %0d point beats (%0d landed, %0d dropped) and %0d pixel reads",
                 plots_landed + plots_dropped, plots_landed, plots_dropped,
                 reads_valid + reads_invalid);
        $display("(%0d in range, %0d out of range) across %0d grid settings.",
                 reads_valid, reads_invalid, settings_used);
        if (mismatches == 0 && due_pixels.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
